>>> rtl/lss_pkg.sv
`timescale 1ns / 1ps
// lss_pkg: shared constants, codes and types for the LIFO stack with search.
// No dependencies; imported by lifo_stack_with_search.
package lss_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LIST   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SRCH,
        S_SRCH_DONE
    } t_state;

endpackage

>>> rtl/lss_ram.sv
`timescale 1ns / 1ps
// lss_ram: simple dual-port RAM, one write and one registered read per cycle.
// Generic; no package dependency. Read data holds when no read is issued.
module lss_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lifo_stack_with_search.sv
`timescale 1ns / 1ps
// lifo_stack_with_search: bounded LIFO of signed 32-bit words with list and search.
// Depends on lss_pkg (constants, codes, state type) and lss_ram (entry storage).

// Stack of up to DEPTH signed 32-bit words held in one RAM with a registered
// read port, plus an entry count. Each input word carries an operation: push,
// pop, list, search or clear; unused codes are accepted and produce nothing.
// Push and clear answer straight from idle; pop reads the RAM, then outputs it.
// List emits one output word per stored entry, newest first, one per cycle
// while the output is not stalled, after an initial RAM read, with last set
// on the oldest; on an empty stack it gives a single empty-status word. Search
// scans the stored entries through the same read port, one compare per cycle,
// and answers. Throughput is therefore bounded by the single RAM read port
// and the number of held entries. A one-word output register sits between the
// engine and the output channel; o_in_stall is low only when the engine is idle
// and that register is empty or being drained this cycle. Output stalls simply
// freeze a list or pop in progress; nothing is dropped.
module lifo_stack_with_search
    import lss_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic        [FUNC_W-1:0]   i_func,
    input  logic signed [DATA_W-1:0]   i_value,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [DATA_W-1:0]   o_result_value,
    output logic        [STATUS_W-1:0] o_status,
    output logic                       o_found,
    output logic                       o_last
);

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;
    // walk context
    logic [ADDR_W-1:0]  r_idx, n_idx;      // address of word now in RAM read data
    logic               r_single, n_single; // pop: one word only
    logic               r_hit, n_hit;
    logic [DATA_W-1:0]  r_key, n_key;
    // output word
    logic [DATA_W-1:0]   r_res, n_res;
    logic [STATUS_W-1:0] r_sts, n_sts;
    logic                r_fnd, n_fnd;
    logic                r_lst, n_lst;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              out_free;
    logic              accept;
    logic [CNT_W-1:0]  cnt_dec;
    logic [ADDR_W-1:0] idx_dec;
    logic              is_empty;
    logic              is_full;

    lss_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign cnt_dec    = r_count - CNT_W'(1);
    assign idx_dec    = r_idx - ADDR_W'(1);
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == CNT_W'(DEPTH));
    assign ram_waddr  = r_count[ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_idx       = r_idx;
        n_single    = r_single;
        n_hit       = r_hit;
        n_key       = r_key;
        n_res       = r_res;
        n_sts       = r_sts;
        n_fnd       = r_fnd;
        n_lst       = r_lst;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = cnt_dec[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // default single-word answer; arms below override
                    n_res = '0;
                    n_sts = STS_OK;
                    n_fnd = 1'b0;
                    n_lst = 1'b1;
                    case (i_func)
                        FN_PUSH: begin
                            n_out_valid = 1'b1;
                            if (is_full) begin
                                n_sts = STS_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        FN_POP: begin
                            if (is_empty) begin
                                n_out_valid = 1'b1;
                                n_sts       = STS_EMPTY;
                            end else begin
                                ram_re   = 1'b1;
                                n_count  = cnt_dec;
                                n_idx    = cnt_dec[ADDR_W-1:0];
                                n_single = 1'b1;
                                n_state  = S_WALK;
                            end
                        end
                        FN_LIST: begin
                            if (is_empty) begin
                                n_out_valid = 1'b1;
                                n_sts       = STS_EMPTY;
                            end else begin
                                ram_re   = 1'b1;
                                n_idx    = cnt_dec[ADDR_W-1:0];
                                n_single = 1'b0;
                                n_state  = S_WALK;
                            end
                        end
                        FN_SEARCH: begin
                            n_key = i_value;
                            n_hit = 1'b0;
                            if (is_empty) begin
                                n_out_valid = 1'b1;
                            end else begin
                                ram_re  = 1'b1;
                                n_idx   = cnt_dec[ADDR_W-1:0];
                                n_state = S_SRCH;
                            end
                        end
                        FN_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_count     = '0;
                        end
                        default: begin
                            // unused code: swallowed, no result
                        end
                    endcase
                end
            end

            S_WALK: begin
                // read data is valid here; emit and, unless it was the last, fetch the next-older word
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = ram_rdata;
                    n_sts       = STS_OK;
                    n_fnd       = 1'b0;
                    n_lst       = r_single || (r_idx == '0);
                    if (r_single || (r_idx == '0)) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_dec;
                        n_idx     = idx_dec;
                    end
                end
            end

            S_SRCH: begin
                n_hit = r_hit || (ram_rdata == r_key);
                if (r_idx == '0) begin
                    n_state = S_SRCH_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec;
                    n_idx     = idx_dec;
                end
            end

            S_SRCH_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = '0;
                    n_sts       = STS_OK;
                    n_fnd       = r_hit;
                    n_lst       = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // walk context and output word
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_single <= n_single;
        r_hit    <= n_hit;
        r_key    <= n_key;
        r_res    <= n_res;
        r_sts    <= n_sts;
        r_fnd    <= n_fnd;
        r_lst    <= n_lst;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_res;
    assign o_status       = r_sts;
    assign o_found        = r_fnd;
    assign o_last         = r_lst;

endmodule
